// ===== src/mandelbrot_membership_iterator_unit_defines.svh =====
// Assertion macros shared by the iterator RTL.
`ifndef MANDELBROT_MEMBERSHIP_ITERATOR_UNIT_DEFINES_SVH
`define MANDELBROT_MEMBERSHIP_ITERATOR_UNIT_DEFINES_SVH
// Assert that a property holds on every clock edge outside reset.
`define MMI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Assert that a condition implies another in the following cycle.
`define MMI_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);
`endif

// ===== src/mmi_pkg.sv =====
// Package with constants, types and helpers for the Mandelbrot iterator.
`timescale 1ns / 1ps
package mmi_pkg;
  localparam int FracBits = 60;
  localparam logic signed [63:0] FxOne = 64'sd1 <<< FracBits;
  localparam logic signed [63:0] K115 = FxOne + (3 * FxOne + 10) / 20;
  localparam logic signed [63:0] KM20 = -2 * FxOne;
  localparam logic signed [63:0] K049 = FxOne / 2 - (FxOne + 50) / 100;
  localparam logic signed [63:0] K40 = 4 * FxOne;
  localparam logic signed [63:0] K025 = FxOne / 4;
  localparam logic signed [63:0] K05 = FxOne / 2;
  localparam logic signed [63:0] KM075 = -(3 * FxOne) / 4;
  localparam logic signed [63:0] KM125 = -(5 * FxOne) / 4;
  localparam logic signed [63:0] K00625 = FxOne / 16;
  localparam logic signed [63:0] K0375 = (3 * FxOne) / 8;
  localparam logic signed [63:0] K065 = FxOne / 2 + (3 * FxOne + 10) / 20;
  localparam logic signed [63:0] SMax = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SMin = -64'sh7FFF_FFFF_FFFF_FFFF - 64'sd1;

  localparam logic [2:0] OutOutside = 3'd0;
  localparam logic [2:0] OutInside  = 3'd1;
  localparam logic [2:0] OutEscaped = 3'd2;
  localparam logic [2:0] OutSettled = 3'd3;
  localparam logic [2:0] OutOrbit   = 3'd4;
  localparam logic [2:0] OutCap     = 3'd5;

  localparam logic [1:0] RegSettle = 2'd0;
  localparam logic [1:0] RegOrbit  = 2'd1;
  localparam logic [1:0] RegCap    = 2'd2;

  typedef struct packed {
    logic signed [63:0] a;
    logic signed [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic signed [63:0] p;
    logic               sat;
  } mul_rsp_t;

  function automatic logic signed [64:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] r;
    r = {a[63], a} + {b[63], b};
    if (r[64] != r[63]) sadd = {1'b1, r[64] ? SMin : SMax};
    else sadd = {1'b0, r[63:0]};
  endfunction

  function automatic logic signed [64:0] ssub(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] r;
    r = {a[63], a} - {b[63], b};
    if (r[64] != r[63]) ssub = {1'b1, r[64] ? SMin : SMax};
    else ssub = {1'b0, r[63:0]};
  endfunction

  function automatic logic [62:0] mag_diff(input logic signed [63:0] a,
                                           input logic signed [63:0] b);
    logic signed [64:0] d;
    logic signed [63:0] v;
    d = ssub(a, b);
    v = d[63:0];
    if (v == SMin) mag_diff = SMax[62:0];
    else if (v[63]) mag_diff = 63'(-v);
    else mag_diff = v[62:0];
  endfunction
endpackage

// ===== src/mmi_mul.sv =====
// Sequential saturating fixed-point multiplier, 32x32 partial products.
`timescale 1ns / 1ps
`include "mandelbrot_membership_iterator_unit_defines.svh"
module mmi_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  mmi_pkg::mul_req_t req_i,
  output logic              done_o,
  output mmi_pkg::mul_rsp_t rsp_o
);
  import mmi_pkg::*;

  logic [63:0]  ua_q, ub_q;
  logic         neg_q;
  logic [127:0] acc_q;
  logic [2:0]   step_q;
  logic         busy_q, done_q;
  logic [63:0]  ua_d, ub_d;
  logic [31:0]  opa, opb;
  logic [63:0]  part;
  logic [127:0] acc_d, prod;
  logic [127:0] sh;

  assign ua_d = req_i.a[63] ? 64'(-req_i.a) : req_i.a;
  assign ub_d = req_i.b[63] ? 64'(-req_i.b) : req_i.b;

  always_comb begin
    unique case (step_q[1:0])
      2'd0: begin opa = ua_q[31:0];  opb = ub_q[31:0];  end
      2'd1: begin opa = ua_q[31:0];  opb = ub_q[63:32]; end
      2'd2: begin opa = ua_q[63:32]; opb = ub_q[31:0];  end
      default: begin opa = ua_q[63:32]; opb = ub_q[63:32]; end
    endcase
    part = opa * opb;
    unique case (step_q[1:0])
      2'd0: acc_d = acc_q + {64'd0, part};
      2'd1, 2'd2: acc_d = acc_q + {32'd0, part, 32'd0};
      default: acc_d = acc_q + {part, 64'd0};
    endcase
  end

  // Apply sign and shift of the finished magnitude product.
  always_comb begin
    prod = neg_q ? 128'(-acc_q) : acc_q;
    sh = 128'($signed(prod) >>> FracBits);
    rsp_o.sat = (sh[127:63] != {65{sh[63]}});
    rsp_o.p = rsp_o.sat ? (sh[127] ? SMin : SMax) : sh[63:0];
  end
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == 3'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ua_q <= ua_d;
      ub_q <= ub_d;
      neg_q <= req_i.a[63] ^ req_i.b[63];
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  `MMI_ASSERT_NEXT(a_done_pulse, done_q, !done_q, "mul done held two cycles")
  `MMI_ASSERT(a_no_restart, !(start_i && busy_q), "mul restarted while busy")
  `MMI_ASSERT_NEXT(a_step_bound, busy_q, step_q <= 3'd3 || !busy_q, "mul step overrun")
endmodule

// ===== src/mandelbrot_membership_iterator_unit.sv =====
// Top level: Mandelbrot membership decider with a shared sequential multiplier.
`timescale 1ns / 1ps
`include "mandelbrot_membership_iterator_unit_defines.svh"
// One point c is taken per beat and yields one result beat. The point is first
// screened (box, radius-2 disc, period-2 bulb, main cardioid), then z = z*z + c
// is iterated with escape and settling checks every fifth step and a half-speed
// tortoise orbit compared on odd steps. All products go through one 64x64
// multiplier built from a single 32x32 partial product per cycle, so every
// multiply runs through issue, four partial products and done. Screening
// ends after the box products (outside), the bulb products or the cardioid
// products; an iterated point adds the tortoise step and compare on odd
// steps and the magnitude products on checked steps, for up to the cap
// register's number of iterations. Input ready is low from acceptance until
// the result beat is taken. Registers sit at 0x00, 0x08, 0x10 (64-bit data).
module mandelbrot_membership_iterator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [63:0] point_re_in_i,
  input  logic signed [63:0] point_im_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  outcome_o,
  output logic [31:0] iter_count_o
);
  import mmi_pkg::*;

  // Sequencer states.
  localparam logic [4:0] SIdle   = 5'd0;
  localparam logic [4:0] SBoxRR  = 5'd1;  // re*re
  localparam logic [4:0] SBoxII  = 5'd2;  // im*im, then screen
  localparam logic [4:0] SBulbXX = 5'd3;  // xp*xp
  localparam logic [4:0] SBulbV  = 5'd4;
  localparam logic [4:0] SCarAA  = 5'd5;  // ax*ax
  localparam logic [4:0] SCarHA  = 5'd6;  // 0.5*ax
  localparam logic [4:0] SCarFF  = 5'd7;  // f*f
  localparam logic [4:0] SCarQQ  = 5'd8;  // 0.25*q
  localparam logic [4:0] SLoop   = 5'd9;
  localparam logic [4:0] SZRR    = 5'd10;
  localparam logic [4:0] SZII    = 5'd11;
  localparam logic [4:0] SZRI    = 5'd12;
  localparam logic [4:0] SMagR   = 5'd13;
  localparam logic [4:0] SMagI   = 5'd14;
  localparam logic [4:0] SSRR    = 5'd15;
  localparam logic [4:0] SSII    = 5'd16;
  localparam logic [4:0] SSRI    = 5'd17;
  localparam logic [4:0] SOut    = 5'd18;
  localparam logic [4:0] SCarQ   = 5'd19;
  localparam logic [4:0] SCmpO   = 5'd20; // compare tortoise with z

  logic [4:0]  state_q;
  logic        wait_q;      // multiply in flight
  logic [62:0] settle_q, orbit_q;
  logic [31:0] cap_q;
  logic signed [63:0] cr_q, ci_q, zr_q, zi_q, pr_q, pi_q, sr_q, si_q;
  logic signed [63:0] t0_q, t1_q;   // scratch products
  logic        sat_q;
  logic [31:0] i_q;
  logic [2:0]  mod5_q;
  logic [2:0]  res_q;

  logic        mstart, mdone;
  mul_req_t    mreq;
  mul_rsp_t    mrsp;

  mmi_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mstart),
    .req_i  (mreq),
    .done_o (mdone),
    .rsp_o  (mrsp)
  );

  // Configuration port.
  logic        wr_en;
  logic [1:0]  reg_idx;
  assign pready = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en = psel && penable && pwrite;
  always_comb begin
    unique case (reg_idx)
      RegSettle: prdata = {1'b0, settle_q};
      RegOrbit:  prdata = {1'b0, orbit_q};
      RegCap:    prdata = {32'd0, cap_q};
      default:   prdata = '0;
    endcase
  end

  // Combinational helpers on scratch values.
  logic signed [64:0] xp, ax, m2, qv, fv, vv, bv, nr0, nr, ni0, ni, mag;
  logic near_set, near_orb, in_box, bulb_sel, car_sel;
  always_comb begin
    xp = sadd(cr_q, FxOne);
    ax = ssub(cr_q, K025);
    m2 = sadd(t0_q, mrsp.p);
    qv = sadd(t0_q, mrsp.p);
    fv = sadd(t1_q, mrsp.p);
    vv = ssub(t0_q, mrsp.p);
    bv = ssub(m2[63:0], K00625);
    nr0 = ssub(t0_q, t1_q);
    nr = sadd(nr0[63:0], cr_q);
    ni0 = sadd(mrsp.p, mrsp.p);
    ni = sadd(ni0[63:0], ci_q);
    mag = sadd(t0_q, mrsp.p);
    in_box = !(ci_q < -K115 || ci_q > K115 || cr_q < KM20 || cr_q > K049 ||
               m2[63:0] > K40);
    bulb_sel = ci_q < K025 && cr_q < KM075 && cr_q > KM125;
    car_sel = cr_q > KM075 && ci_q < K065 && cr_q < K0375;
    near_set = mag_diff(pr_q, zr_q) < settle_q && mag_diff(pi_q, zi_q) < settle_q;
    near_orb = mag_diff(sr_q, zr_q) < orbit_q && mag_diff(si_q, zi_q) < orbit_q;
  end

  // Operand select for the shared multiplier.
  always_comb begin
    unique case (state_q)
      SBoxRR:  mreq = '{cr_q, cr_q};
      SBoxII, SBulbV, SCarQ: mreq = '{ci_q, ci_q};
      SBulbXX: mreq = '{xp[63:0], xp[63:0]};
      SCarAA:  mreq = '{ax[63:0], ax[63:0]};
      SCarHA:  mreq = '{K05, ax[63:0]};
      SCarFF:  mreq = '{t1_q, t1_q};
      SCarQQ:  mreq = '{K025, t1_q};
      SZRR:    mreq = '{zr_q, zr_q};
      SZII:    mreq = '{zi_q, zi_q};
      SZRI:    mreq = '{zr_q, zi_q};
      SMagR:   mreq = '{zr_q, zr_q};
      SMagI:   mreq = '{zi_q, zi_q};
      SSRR:    mreq = '{sr_q, sr_q};
      SSII:    mreq = '{si_q, si_q};
      SSRI:    mreq = '{sr_q, si_q};
      default: mreq = '{cr_q, ci_q};
    endcase
  end

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);
  assign outcome_o = res_q;
  assign iter_count_o = i_q;
  assign mstart = !wait_q && state_q != SIdle && state_q != SOut &&
                  state_q != SLoop && state_q != SCmpO;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      wait_q   <= 1'b0;
      settle_q <= 63'd1048576;
      orbit_q  <= 63'd1048576;
      cap_q    <= 32'd1000000;
    end else begin
      if (wr_en) begin
        unique case (reg_idx)
          RegSettle: settle_q <= pwdata[62:0];
          RegOrbit:  orbit_q  <= pwdata[62:0];
          RegCap:    cap_q    <= pwdata[31:0];
          default: ;
        endcase
      end
      if (mstart) wait_q <= 1'b1;
      if (mdone) wait_q <= 1'b0;
      if (state_q == SIdle) begin
        if (in_acc) state_q <= SBoxRR;
      end else if (state_q == SOut) begin
        if (out_ready_i) state_q <= SIdle;
      end else if (state_q == SLoop) begin
        state_q <= (i_q == cap_q) ? SOut : SZRR;
      end else if (state_q == SCmpO) begin
        state_q <= near_orb ? SOut : SLoop;
      end else if (mdone) begin
        unique case (state_q)
          SBoxRR:  state_q <= SBoxII;
          SBoxII: begin
            if (!in_box) state_q <= SOut;
            else if (bulb_sel) state_q <= SBulbXX;
            else if (car_sel) state_q <= SCarAA;
            else state_q <= SLoop;
          end
          SBulbXX: state_q <= SBulbV;
          SBulbV:  state_q <= bv[63] ? SOut : SLoop;
          SCarAA:  state_q <= SCarQ;
          SCarQ:   state_q <= SCarHA;
          SCarHA:  state_q <= SCarFF;
          SCarFF:  state_q <= SCarQQ;
          SCarQQ:  state_q <= vv[63] ? SOut : SLoop;
          SZRR:    state_q <= SZII;
          SZII:    state_q <= SZRI;
          SZRI: begin
            if (sat_q || mrsp.sat || nr0[64] || nr[64] || ni0[64] || ni[64])
              state_q <= SOut;
            else if (mod5_q == 3'd1) state_q <= SMagR;
            else if (i_q[0]) state_q <= SSRR;
            else state_q <= SLoop;
          end
          SMagR:   state_q <= SMagI;
          SMagI: begin
            if (mag[63:0] > K40 || near_set) state_q <= SOut;
            else if (i_q[0]) state_q <= SSRR;
            else state_q <= SLoop;
          end
          SSRR:    state_q <= SSII;
          SSII:    state_q <= SSRI;
          SSRI: begin
            if (sat_q || mrsp.sat || nr0[64] || nr[64] || ni0[64] || ni[64])
              state_q <= SOut;
            else state_q <= SCmpO;
          end
          default: state_q <= SIdle;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && in_acc) begin
      cr_q <= point_re_in_i; ci_q <= point_im_in_i;
      zr_q <= point_re_in_i; zi_q <= point_im_in_i;
      pr_q <= point_re_in_i; pi_q <= point_im_in_i;
      sr_q <= point_re_in_i; si_q <= point_im_in_i;
      i_q <= '0; mod5_q <= '0; sat_q <= 1'b0;
      res_q <= OutOutside;
    end else if (state_q == SLoop) begin
      if (i_q == cap_q) res_q <= OutCap;
      sat_q <= 1'b0;
      pr_q <= zr_q; pi_q <= zi_q;
    end else if (state_q == SCmpO) begin
      // Advance the step index unless the tortoise caught up.
      if (!near_orb) begin
        i_q <= i_q + 32'd1;
        mod5_q <= (mod5_q == 3'd4) ? 3'd0 : mod5_q + 3'd1;
      end
    end else if (mdone) begin
      unique case (state_q)
        SBoxRR: t0_q <= mrsp.p;
        SBoxII: begin
          t0_q <= m2[63:0];
          res_q <= in_box ? OutInside : OutOutside;
        end
        SBulbXX: t0_q <= mrsp.p;
        SBulbV: t0_q <= qv[63:0];
        SCarAA: t0_q <= mrsp.p;
        // Keep q in t0 while t1 carries f.
        SCarQ: begin
          t0_q <= qv[63:0];
          t1_q <= qv[63:0];
        end
        SCarHA: t1_q <= fv[63:0];
        SCarFF: begin
          t0_q <= mrsp.p;
          t1_q <= t0_q;
        end
        SCarQQ: ;
        SZRR, SSRR: begin t0_q <= mrsp.p; sat_q <= mrsp.sat; end
        SZII, SSII: begin t1_q <= mrsp.p; sat_q <= sat_q | mrsp.sat; end
        SZRI: begin
          zr_q <= nr[63:0]; zi_q <= ni[63:0];
          res_q <= OutEscaped;
          if (!(sat_q || mrsp.sat || nr0[64] || nr[64] || ni0[64] || ni[64]) &&
              mod5_q != 3'd1 && !i_q[0]) begin
            i_q <= i_q + 32'd1;
            mod5_q <= (mod5_q == 3'd4) ? 3'd0 : mod5_q + 3'd1;
          end
        end
        SMagR: t0_q <= mrsp.p;
        SMagI: begin
          res_q <= (mag[63:0] > K40) ? OutEscaped : OutSettled;
          if (!(mag[63:0] > K40 || near_set) && !i_q[0]) begin
            i_q <= i_q + 32'd1;
            mod5_q <= (mod5_q == 3'd4) ? 3'd0 : mod5_q + 3'd1;
          end
        end
        SSRI: begin
          sr_q <= nr[63:0]; si_q <= ni[63:0];
          res_q <= (sat_q || mrsp.sat || nr0[64] || nr[64] || ni0[64] || ni[64]) ?
                   OutEscaped : OutOrbit;
        end
        default: ;
      endcase
    end
  end

  `MMI_ASSERT(a_ready_idle, !(in_ready_o && out_valid_o), "ready and valid together")
  `MMI_ASSERT(a_no_mul_in_out, !(out_valid_o && wait_q), "multiply pending on output")
  `MMI_ASSERT(a_mod5_range, mod5_q <= 3'd4 || state_q == SIdle, "iteration phase out of range")
  `MMI_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                   out_valid_o && $stable(res_q) && $stable(i_q), "result beat changed")
endmodule

// ===== tb/sv/mandelbrot_membership_iterator_unit_test.sv =====
// Self-checking testbench for the Mandelbrot membership iterator unit.
`timescale 1ns / 1ps
module mandelbrot_membership_iterator_unit_test;
  import mmi_pkg::*;

  typedef struct {
    logic [2:0]  outcome;
    logic [31:0] count;
  } verdict_t;

  // Scoreboard: predicts one verdict per accepted point and holds it in order.
  class membership_board;
    logic [62:0] settle_thr = 63'd1048576;
    logic [62:0] orbit_thr  = 63'd1048576;
    logic [31:0] cap        = 32'd1000000;
    verdict_t    pending_verdicts[$];
    int          mismatches;
    int          checked;
    int          tally[6];
    bit          clipped;
    logic signed [63:0] c_re, c_im;

    function logic signed [63:0] qadd(logic signed [63:0] a, logic signed [63:0] b);
      logic [64:0] r;
      r = {a[63], a} + {b[63], b};
      if (r[64] != r[63]) begin
        clipped = 1;
        return r[64] ? SMin : SMax;
      end
      return r[63:0];
    endfunction

    function logic signed [63:0] qsub(logic signed [63:0] a, logic signed [63:0] b);
      logic [64:0] r;
      r = {a[63], a} - {b[63], b};
      if (r[64] != r[63]) begin
        clipped = 1;
        return r[64] ? SMin : SMax;
      end
      return r[63:0];
    endfunction

    function logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [127:0] wa, wb, q;
      wa = a;
      wb = b;
      q = (wa * wb) >>> FracBits;
      if (q[127:63] != {65{q[63]}}) begin
        clipped = 1;
        return q[127] ? SMin : SMax;
      end
      return q[63:0];
    endfunction

    // Saturation inside the checks never decides anything: keep the flag.
    function bit close_to(logic signed [63:0] ar, logic signed [63:0] ai,
                          logic signed [63:0] br, logic signed [63:0] bi,
                          logic [62:0] thr);
      bit keep;
      logic signed [63:0] dr, di;
      keep = clipped;
      dr = qsub(ar, br);
      di = qsub(ai, bi);
      dr = (dr == SMin) ? SMax : (dr < 0 ? -dr : dr);
      di = (di == SMin) ? SMax : (di < 0 ? -di : di);
      clipped = keep;
      return (64'(dr) < {1'b0, thr}) && (64'(di) < {1'b0, thr});
    endfunction

    // One orbit step w = w*w + c; returns high on saturation.
    function bit square_add(inout logic signed [63:0] wr, inout logic signed [63:0] wi);
      logic signed [63:0] rr, ii, ri;
      clipped = 0;
      rr = qmul(wr, wr);
      ii = qmul(wi, wi);
      ri = qmul(wr, wi);
      wr = qadd(qsub(rr, ii), c_re);
      wi = qadd(qadd(ri, ri), c_im);
      return clipped;
    endfunction

    function verdict_t predict_membership(logic signed [63:0] re, logic signed [63:0] im);
      verdict_t v;
      logic signed [63:0] m2, xp, ax, q, f, t, zr, zi, pr, pi, sr, si;
      longint unsigned i;
      c_re = re;
      c_im = im;
      v.count = 0;
      m2 = qadd(qmul(re, re), qmul(im, im));
      if (im < -K115 || im > K115 || re < KM20 || re > K049 || m2 > K40) begin
        v.outcome = OutOutside;
        return v;
      end
      v.outcome = OutInside;
      if (im < K025 && re < KM075 && re > KM125) begin
        xp = qadd(re, FxOne);
        t = qsub(qadd(qmul(xp, xp), qmul(im, im)), K00625);
        if (t < 0) return v;
      end else if (re > KM075 && im < K065 && re < K0375) begin
        ax = qsub(re, K025);
        q = qadd(qmul(ax, ax), qmul(im, im));
        f = qadd(q, qmul(K05, ax));
        t = qsub(qmul(f, f), qmul(K025, q));
        if (t < 0) return v;
      end
      zr = re; zi = im; sr = re; si = im;
      for (i = 0; i < cap; i++) begin
        v.count = i[31:0];
        pr = zr;
        pi = zi;
        v.outcome = OutEscaped;
        if (square_add(zr, zi)) return v;
        if (i % 5 == 1) begin
          if (qadd(qmul(zr, zr), qmul(zi, zi)) > K40) return v;
          v.outcome = OutSettled;
          if (close_to(pr, pi, zr, zi, settle_thr)) return v;
        end
        if (i[0]) begin
          v.outcome = OutEscaped;
          if (square_add(sr, si)) return v;
          v.outcome = OutOrbit;
          if (close_to(sr, si, zr, zi, orbit_thr)) return v;
        end
      end
      v.outcome = OutCap;
      v.count = cap;
      return v;
    endfunction

    function void note_point(logic signed [63:0] re, logic signed [63:0] im);
      pending_verdicts.push_back(predict_membership(re, im));
    endfunction

    function void check_result(logic [2:0] outcome, logic [31:0] count);
      verdict_t e;
      checked++;
      if (outcome < 6) tally[outcome]++;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: outcome %0d count %0d", outcome, count);
        return;
      end
      e = pending_verdicts.pop_front();
      if (outcome !== e.outcome || count !== e.count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: outcome exp %0d got %0d, count exp %0d got %0d",
                   e.outcome, outcome, e.count, count);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic in_valid_i = 0;
  logic in_ready_o;
  logic signed [63:0] point_re_in_i = '0, point_im_in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  logic [2:0] outcome_o;
  logic [31:0] iter_count_o;

  membership_board board = new();
  bit valid_up;
  int burst_left;
  int stall_mode, stall_left;

  mandelbrot_membership_iterator_unit u_top (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .point_re_in_i, .point_im_in_i,
    .out_valid_o, .out_ready_i, .outcome_o, .iter_count_o
  );

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  // Note every accepted point and check every accepted result beat.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) board.note_point(point_re_in_i, point_im_in_i);
    if (rst_ni && out_valid_o && out_ready_i) board.check_result(outcome_o, iter_count_o);
  end

  // Receiver stalls: switch between always ready, coin flip and rare ready.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(8, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= $urandom_range(0, 1);
      default: out_ready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Write one register through a setup and an access cycle; the block is idle.
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= value;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      RegSettle: board.settle_thr = value[62:0];
      RegOrbit:  board.orbit_thr = value[62:0];
      default:   board.cap = value[31:0];
    endcase
  endtask

  // Drive one point beat; hold it until taken, then maybe end the burst.
  task automatic send_point(input logic signed [63:0] re, input logic signed [63:0] im);
    in_valid_i <= 1; valid_up = 1;
    point_re_in_i <= re; point_im_in_i <= im;
    do @(posedge clk_i); while (!in_ready_o);
    if (burst_left == 0) begin
      in_valid_i <= 0; valid_up = 0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      burst_left = $urandom_range(0, 12);
    end else begin
      burst_left--;
    end
  endtask

  // Drop valid and hold until every predicted verdict has come back.
  task automatic drain;
    if (valid_up) begin
      in_valid_i <= 0; valid_up = 0;
      @(posedge clk_i);
    end
    while (board.pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure(input logic [62:0] s, input logic [62:0] o, input logic [31:0] c);
    drain();
    write_reg(RegSettle, {1'b0, s});
    write_reg(RegOrbit, {1'b0, o});
    write_reg(RegCap, {32'd0, c});
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly points inside the screening box, some raw 64-bit noise.
  task automatic send_random_point;
    logic [63:0] re, im;
    if ($urandom_range(0, 9) < 2) begin
      re = rand64();
      im = rand64();
    end else begin
      re = KM20 + rand64() % 64'(K049 - KM20 + 1);
      im = -K115 + rand64() % 64'(2 * K115 + 1);
    end
    send_point(re, im);
  endtask

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [62:0] s, o;
    logic [31:0] c;
    burst_left = 3;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Reset settings: only points decided during screening.
    send_point(0, 0);
    send_point(-FxOne, 0);
    send_point(SMax, SMax);
    send_point(SMin, SMin);
    send_point(SMin, 0);
    send_point(0, SMax);
    send_point(K049 + 1, 0);
    send_point(0, -K115 - 1);
    send_point(-K05, K05);

    // Iterated corners: fixed point at -2, cardioid boundary, saturating edge.
    configure(63'd1048576, 63'd1048576, 32'd40);
    send_point(KM20, 0);
    send_point(K025, 0);
    send_point(KM075, 0);
    send_point(K049, K115);
    send_point(K049, 0);
    send_point(-K05 / 5, K115 - K025);
    send_point(KM20, K115 / 8);
    configure(63'd0, 63'd0, 32'd0);
    send_point(K025, 0);
    send_point(KM075, K05 / 4);
    configure(63'h7FFF_FFFF_FFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_point(K025, 0);
    send_point(KM20, 0);
    send_point(K049, K115);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin s = 0; o = 0; c = 30; end
        1: begin s = 63'h7FFF_FFFF_FFFF_FFFF; o = 63'h7FFF_FFFF_FFFF_FFFF; c = 32'hFFFF_FFFF; end
        2: begin s = 63'd1048576; o = 63'd1048576; c = 64; end
        3: begin s = 63'({$urandom, $urandom} >> 20); o = 63'({$urandom, $urandom} >> 20);
          c = 1; end
        4: begin s = 63'h7FFF_FFFF_FFFF_FFFF; o = 0; c = $urandom_range(2, 48); end
        default: begin s = 63'({$urandom, $urandom} >> $urandom_range(1, 40));
          o = 63'({$urandom, $urandom} >> $urandom_range(1, 40)); c = $urandom_range(2, 48); end
      endcase
      configure(s, o, c);
      for (int n = 0; n < 46; n++) begin
        if (ph == 2 && n == 20) drain();
        send_random_point();
      end
    end

    drain();
    repeat (200) @(posedge clk_i);
    $display("Checked %0d result beats: outside %0d, inside %0d, escaped %0d,",
             board.checked, board.tally[0], board.tally[1], board.tally[2]);
    $display("settled %0d, orbit %0d, cap %0d; %0d mismatches",
             board.tally[3], board.tally[4], board.tally[5], board.mismatches);
    if (board.mismatches == 0 && board.pending_verdicts.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
